FILE: sv/glms_pkg.sv
// ============================================================================
// glms_pkg: shared types and constants of the linear move segmenter
// Field widths, reset values, command codes and the structs passed between
// the input register, the execution stage and the output register.
// ============================================================================
package glms_pkg;

    localparam int NUM_FEATURES_DEF = 15;

    localparam int COORD_W  = 32;
    localparam int SIZE_W   = 16;
    localparam int FEAT_W   = 4;
    localparam int LAYER_W  = 20;
    localparam int COUNT_W  = 32;
    localparam int MASK_W   = 15;
    localparam int ACTION_W = 4;

    localparam logic [LAYER_W-1:0] LAYER_MAX      = '1;
    localparam logic [SIZE_W-1:0]  WIDTH_RESET    = 16'd420;
    localparam logic [SIZE_W-1:0]  HEIGHT_RESET   = 16'd200;
    localparam logic [MASK_W-1:0]  AID_MASK_RESET = 15'd11776;

    // Command codes carried in the action field.
    typedef enum logic [ACTION_W-1:0] {
        ACT_MOVE      = 4'd0,
        ACT_SET_E     = 4'd1,
        ACT_ABS_POS   = 4'd2,
        ACT_REL_POS   = 4'd3,
        ACT_ABS_E     = 4'd4,
        ACT_REL_E     = 4'd5,
        ACT_NEXT_LYR  = 4'd6,
        ACT_HEIGHT    = 4'd7,
        ACT_WIDTH     = 4'd8,
        ACT_FEATURE   = 4'd9
    } action_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = MASK_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PART_ONLY = 1'b0,
        CFG_AID_MASK  = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic              part_only;
        logic [MASK_W-1:0] aid_mask;
    } cfg_t;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic                      has_x;
        logic signed [COORD_W-1:0] x_value;
        logic                      has_y;
        logic signed [COORD_W-1:0] y_value;
        logic                      has_z;
        logic signed [COORD_W-1:0] z_value;
        logic                      has_e;
        logic signed [COORD_W-1:0] e_value;
        logic [SIZE_W-1:0]         size_value;
        logic [FEAT_W-1:0]         feature_code;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic [SIZE_W-1:0]         bead_width;
        logic [SIZE_W-1:0]         line_height;
        logic [FEAT_W-1:0]         segment_feature;
        logic [LAYER_W-1:0]        segment_layer;
        logic [COUNT_W-1:0]        feature_total;
    } seg_t;

    // Handshake between the execution stage and the output register.
    typedef struct packed {
        logic load;
        logic free;
    } out_ctl_t;

endpackage

FILE: sv/glms_cmd_if.sv
// ============================================================================
// glms_cmd_if: command channel
// Valid/ready channel carrying one tokenized G-code command per request.
// ============================================================================
interface glms_cmd_if;
    logic                                       valid;
    logic                                       ready;
    logic [glms_pkg::ACTION_W-1:0]              action;
    logic                                       has_x;
    logic signed [glms_pkg::COORD_W-1:0]        x_value;
    logic                                       has_y;
    logic signed [glms_pkg::COORD_W-1:0]        y_value;
    logic                                       has_z;
    logic signed [glms_pkg::COORD_W-1:0]        z_value;
    logic                                       has_e;
    logic signed [glms_pkg::COORD_W-1:0]        e_value;
    logic [glms_pkg::SIZE_W-1:0]                size_value;
    logic [glms_pkg::FEAT_W-1:0]                feature_code;

    modport source (
        output valid, action, has_x, x_value, has_y, y_value, has_z, z_value,
               has_e, e_value, size_value, feature_code,
        input  ready
    );

    modport sink (
        input  valid, action, has_x, x_value, has_y, y_value, has_z, z_value,
               has_e, e_value, size_value, feature_code,
        output ready
    );
endinterface

FILE: sv/glms_seg_if.sv
// ============================================================================
// glms_seg_if: segment channel
// Valid/ready channel carrying one extruded segment per request.
// ============================================================================
interface glms_seg_if;
    logic                                valid;
    logic                                ready;
    logic signed [glms_pkg::COORD_W-1:0] start_x;
    logic signed [glms_pkg::COORD_W-1:0] start_y;
    logic signed [glms_pkg::COORD_W-1:0] start_z;
    logic signed [glms_pkg::COORD_W-1:0] end_x;
    logic signed [glms_pkg::COORD_W-1:0] end_y;
    logic signed [glms_pkg::COORD_W-1:0] end_z;
    logic [glms_pkg::SIZE_W-1:0]         bead_width;
    logic [glms_pkg::SIZE_W-1:0]         line_height;
    logic [glms_pkg::FEAT_W-1:0]         segment_feature;
    logic [glms_pkg::LAYER_W-1:0]        segment_layer;
    logic [glms_pkg::COUNT_W-1:0]        feature_total;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
               bead_width, line_height, segment_feature, segment_layer,
               feature_total,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
               bead_width, line_height, segment_feature, segment_layer,
               feature_total,
        output ready
    );
endinterface

FILE: sv/glms_in_reg.sv
// ============================================================================
// glms_in_reg: command input register
// Captures one command request and holds it until the execution stage takes it.
// ============================================================================
module glms_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    glms_cmd_if.sink        cmd,
    input  logic            take,
    output logic            item_vld,
    output glms_pkg::cmd_t  item
);

    logic           vld_reg;
    glms_pkg::cmd_t item_reg;
    logic           open;

    // The register can load when it is empty or its item leaves this cycle.
    assign open      = !vld_reg || take;
    assign cmd.ready = open;
    assign item_vld  = vld_reg;
    assign item      = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (open)
        begin
            vld_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (open && cmd.valid)
        begin
            item_reg.action       <= cmd.action;
            item_reg.has_x        <= cmd.has_x;
            item_reg.x_value      <= cmd.x_value;
            item_reg.has_y        <= cmd.has_y;
            item_reg.y_value      <= cmd.y_value;
            item_reg.has_z        <= cmd.has_z;
            item_reg.z_value      <= cmd.z_value;
            item_reg.has_e        <= cmd.has_e;
            item_reg.e_value      <= cmd.e_value;
            item_reg.size_value   <= cmd.size_value;
            item_reg.feature_code <= cmd.feature_code;
        end
    end

endmodule

FILE: sv/glms_exec.sv
// ============================================================================
// glms_exec: command execution stage
// Holds the machine state, applies one command per cycle while the output
// register is free and builds the segment for extruding moves.
// ============================================================================
module glms_exec #(
    parameter int NUM_FEATURES = glms_pkg::NUM_FEATURES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  glms_pkg::cfg_t      cfg,
    input  logic                item_vld,
    input  glms_pkg::cmd_t      item,
    output logic                take,
    output glms_pkg::out_ctl_t  out_ctl_load,
    input  glms_pkg::out_ctl_t  out_ctl_free,
    output glms_pkg::seg_t      seg_data
);

    localparam int FIDX_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam logic [glms_pkg::FEAT_W-1:0] FEAT_OTHER = glms_pkg::FEAT_W'(NUM_FEATURES - 1);

    logic signed [glms_pkg::COORD_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [glms_pkg::COORD_W-1:0] last_e_reg;
    logic                                abs_mode_reg;
    logic                                rel_e_reg;
    logic [glms_pkg::FEAT_W-1:0]         feature_reg;
    logic [glms_pkg::SIZE_W-1:0]         width_reg;
    logic [glms_pkg::SIZE_W-1:0]         height_reg;
    logic                                layer_started_reg;
    logic [glms_pkg::LAYER_W-1:0]        layer_reg;
    logic [glms_pkg::COUNT_W-1:0]        counts_reg [NUM_FEATURES];

    logic signed [glms_pkg::COORD_W-1:0] pos_x_next, pos_y_next, pos_z_next;
    logic signed [glms_pkg::COORD_W:0]   e_delta;
    logic                                e_positive;
    logic [glms_pkg::MASK_W:0]           aid_vec;
    logic                                is_aid;
    logic                                is_move;
    logic                                emit;
    logic [FIDX_W-1:0]                   fidx;
    logic [glms_pkg::COUNT_W-1:0]        count_cur;
    logic [glms_pkg::COUNT_W-1:0]        count_next;
    logic [glms_pkg::FEAT_W-1:0]         feature_next;
    logic                                go;

    assign go   = item_vld && out_ctl_free.free;
    assign take = go;

    always_comb
    begin
        pos_x_next = !item.has_x ? pos_x_reg :
                     (abs_mode_reg ? item.x_value : pos_x_reg + item.x_value);
        pos_y_next = !item.has_y ? pos_y_reg :
                     (abs_mode_reg ? item.y_value : pos_y_reg + item.y_value);
        pos_z_next = !item.has_z ? pos_z_reg :
                     (abs_mode_reg ? item.z_value : pos_z_reg + item.z_value);

        // Absolute E: exact 33-bit difference so a wrap never looks like extrusion.
        e_delta    = {item.e_value[glms_pkg::COORD_W-1], item.e_value}
                   - {last_e_reg[glms_pkg::COORD_W-1], last_e_reg};
        e_positive = rel_e_reg
                   ? (!item.e_value[glms_pkg::COORD_W-1] && (item.e_value != '0))
                   : (!e_delta[glms_pkg::COORD_W] && (e_delta != '0));

        aid_vec = {1'b0, cfg.aid_mask};
        is_aid  = aid_vec[feature_reg];
        is_move = (item.action == glms_pkg::ACT_MOVE);
        emit    = is_move && item.has_e && e_positive && (item.has_x || item.has_y)
                  && !(cfg.part_only && is_aid);

        fidx       = feature_reg[FIDX_W-1:0];
        count_cur  = counts_reg[fidx];
        count_next = (count_cur == '1) ? count_cur : count_cur + 32'd1;

        feature_next = ({1'b0, item.feature_code} < (glms_pkg::FEAT_W + 1)'(NUM_FEATURES))
                     ? item.feature_code : FEAT_OTHER;
    end

    always_comb
    begin
        seg_data.start_x         = pos_x_reg;
        seg_data.start_y         = pos_y_reg;
        seg_data.start_z         = pos_z_reg;
        seg_data.end_x           = pos_x_next;
        seg_data.end_y           = pos_y_next;
        seg_data.end_z           = pos_z_next;
        seg_data.bead_width      = width_reg;
        seg_data.line_height     = height_reg;
        seg_data.segment_feature = feature_reg;
        seg_data.segment_layer   = layer_reg;
        seg_data.feature_total   = count_next;
    end

    assign out_ctl_load.load = go && emit;
    assign out_ctl_load.free = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            pos_z_reg         <= '0;
            last_e_reg        <= '0;
            abs_mode_reg      <= 1'b1;
            rel_e_reg         <= 1'b1;
            feature_reg       <= FEAT_OTHER;
            width_reg         <= glms_pkg::WIDTH_RESET;
            height_reg        <= glms_pkg::HEIGHT_RESET;
            layer_started_reg <= 1'b0;
            layer_reg         <= '0;
        end
        else if (go)
        begin
            case (item.action)
                glms_pkg::ACT_MOVE:
                begin
                    pos_x_reg <= pos_x_next;
                    pos_y_reg <= pos_y_next;
                    pos_z_reg <= pos_z_next;
                    if (item.has_e && !rel_e_reg)
                    begin
                        last_e_reg <= item.e_value;
                    end
                end
                glms_pkg::ACT_SET_E:
                begin
                    if (item.has_e)
                    begin
                        last_e_reg <= item.e_value;
                    end
                end
                glms_pkg::ACT_ABS_POS:  abs_mode_reg <= 1'b1;
                glms_pkg::ACT_REL_POS:  abs_mode_reg <= 1'b0;
                glms_pkg::ACT_ABS_E:    rel_e_reg    <= 1'b0;
                glms_pkg::ACT_REL_E:    rel_e_reg    <= 1'b1;
                glms_pkg::ACT_NEXT_LYR:
                begin
                    // The first layer change only lifts the index from -1 to 0.
                    if (!layer_started_reg)
                    begin
                        layer_started_reg <= 1'b1;
                    end
                    else if (layer_reg != glms_pkg::LAYER_MAX)
                    begin
                        layer_reg <= layer_reg + 20'd1;
                    end
                end
                glms_pkg::ACT_HEIGHT:   height_reg  <= item.size_value;
                glms_pkg::ACT_WIDTH:    width_reg   <= item.size_value;
                glms_pkg::ACT_FEATURE:  feature_reg <= feature_next;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FEATURES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (go && emit)
        begin
            counts_reg[fidx] <= count_next;
        end
    end

endmodule

FILE: sv/glms_out_reg.sv
// ============================================================================
// glms_out_reg: segment output register
// Holds one finished segment until the receiver takes it.
// ============================================================================
module glms_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  glms_pkg::out_ctl_t  ctl_in,
    output glms_pkg::out_ctl_t  ctl_out,
    input  glms_pkg::seg_t      seg_data,
    glms_seg_if.source          seg
);

    logic           vld_reg;
    glms_pkg::seg_t data_reg;
    logic           free;

    // The slot is free when empty or when its segment is taken this cycle.
    assign free         = !vld_reg || seg.ready;
    assign ctl_out.free = free;
    assign ctl_out.load = vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (free)
        begin
            vld_reg <= ctl_in.load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && ctl_in.load)
        begin
            data_reg <= seg_data;
        end
    end

    assign seg.valid           = vld_reg;
    assign seg.start_x         = data_reg.start_x;
    assign seg.start_y         = data_reg.start_y;
    assign seg.start_z         = data_reg.start_z;
    assign seg.end_x           = data_reg.end_x;
    assign seg.end_y           = data_reg.end_y;
    assign seg.end_z           = data_reg.end_z;
    assign seg.bead_width      = data_reg.bead_width;
    assign seg.line_height     = data_reg.line_height;
    assign seg.segment_feature = data_reg.segment_feature;
    assign seg.segment_layer   = data_reg.segment_layer;
    assign seg.feature_total   = data_reg.feature_total;

endmodule

FILE: sv/gcode_linear_move_segmenter.sv
// ============================================================================
// gcode_linear_move_segmenter: G-code linear move segmenter
// Turns tokenized G-code commands into extruded line segments with their
// width, height, layer, feature and running per-feature count.
// ============================================================================
// Usage:
// Commands arrive on the cmd channel (valid/ready), one per request. Each is
// applied to the tracked state: position, positioning and extrusion modes,
// last absolute E, feature, width, height, layer and per-feature counts.
// A G0/G1 move with X or Y and a positive extrusion delta yields one request
// on the seg channel, unless part_only is set and the current feature is in
// the aid mask; all other commands yield none. An accepted command is held in
// the input register, then the execution stage feeds its segment into the
// output register. Throughput is one command per cycle while the output
// register is free; the only path between input and output is a short
// add/compare stage plus one count increment. The output register decouples
// the sides: while a segment waits, the stage behind it stalls, so cmd.ready drops only when both registers are full.
// Reset (rst_n low, asynchronous) empties both registers and restores the
// state: origin position, absolute positioning, relative E, feature "other",
// width 420 um, height 200 um, no layer yet, all counts zero, part_only off
// and the aid mask at its default. Configuration writes take effect at once.
// ============================================================================
module gcode_linear_move_segmenter #(
    parameter int NUM_FEATURES = glms_pkg::NUM_FEATURES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [glms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [glms_pkg::CFG_DATA_W-1:0]     cfg_data,
    glms_cmd_if.sink                            cmd,
    glms_seg_if.source                          seg
);

    // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
    logic                          part_only_reg;
    logic [glms_pkg::MASK_W-1:0]   aid_mask_reg;
    glms_pkg::cfg_t                cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_only_reg <= 1'b0;
            aid_mask_reg  <= glms_pkg::AID_MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                glms_pkg::CFG_PART_ONLY: part_only_reg <= cfg_data[0];
                glms_pkg::CFG_AID_MASK:  aid_mask_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.part_only = part_only_reg;
    assign cfg.aid_mask  = aid_mask_reg;

    logic                item_vld;
    glms_pkg::cmd_t      item;
    logic                take;
    glms_pkg::out_ctl_t  load_ctl;
    glms_pkg::out_ctl_t  free_ctl;
    glms_pkg::seg_t      seg_data;

    // Input register: holds the accepted command for the execution stage.
    glms_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .take     (take),
        .item_vld (item_vld),
        .item     (item)
    );

    // Execution stage: state update and segment assembly.
    glms_exec #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_vld     (item_vld),
        .item         (item),
        .take         (take),
        .out_ctl_load (load_ctl),
        .out_ctl_free (free_ctl),
        .seg_data     (seg_data)
    );

    // Output register: presents the segment until the receiver takes it.
    glms_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (load_ctl),
        .ctl_out  (free_ctl),
        .seg_data (seg_data),
        .seg      (seg)
    );

endmodule

FILE: sv/glms_checker.sv
// ============================================================================
// glms_checker: port-level checks of the segmenter
// Watches the command and segment channels and checks their timing relation.
// ============================================================================
module glms_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          seg_valid,
    input logic                          seg_ready,
    input logic [glms_pkg::COORD_W-1:0]  seg_end_x,
    input logic [glms_pkg::COUNT_W-1:0]  seg_total
);

    // A stalled segment stays offered.
    a_seg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_ready |=> seg_valid)
        else $error("segment dropped while stalled");

    // A stalled segment keeps its payload.
    a_seg_stable: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_ready |=> $stable(seg_end_x) && $stable(seg_total))
        else $error("segment payload changed while stalled");

    // A fresh segment is checked against an earlier command handshake on the cmd channel.
    a_seg_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(seg_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("segment without a preceding command");

    // Every emitted segment counts itself.
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> seg_total != '0)
        else $error("segment with zero feature count");

endmodule

bind gcode_linear_move_segmenter glms_checker u_glms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .seg_valid (seg.valid),
    .seg_ready (seg.ready),
    .seg_end_x (seg.end_x),
    .seg_total (seg.feature_total)
);
